// File: design/orlb_pkg.sv
// shared constants and types for the overwrite ring log buffer
// no dependencies; used by every other design file

package orlb_pkg;

    // ring depth; the address arithmetic relies on it being a power of two
    localparam int unsigned DEPTH  = 8192;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned BYTE_W = 8;

    // request codes
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // memory command from the pointer logic
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_mem_cmd;

    // per-item result info that travels beside the memory read
    typedef struct packed {
        logic             rd_ok;
        logic [CNT_W-1:0] count;
    } t_item_info;

endpackage

// File: design/orlb_if.sv
// valid/ready channel interfaces for the request and response sides
// depends on orlb_pkg for field widths

interface orlb_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [orlb_pkg::BYTE_W-1:0]     byte_in;
    logic [orlb_pkg::ADDR_W-1:0]     read_index;

    modport source (output valid, req_type, byte_in, read_index, input ready);
    modport sink   (input valid, req_type, byte_in, read_index, output ready);
endinterface

interface orlb_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [orlb_pkg::BYTE_W-1:0]     read_byte;
    logic                            read_valid;
    logic [orlb_pkg::CNT_W-1:0]      stored_count;

    modport source (output valid, read_byte, read_valid, stored_count, input ready);
    modport sink   (input valid, read_byte, read_valid, stored_count, output ready);
endinterface

// File: design/orlb_mem.sv
// byte storage of the ring: one write port, one registered read port
// depends on orlb_pkg for the command type and sizes

module orlb_mem (
    input  logic                        i_clk,
    input  orlb_pkg::t_mem_cmd          i_cmd,
    output logic [orlb_pkg::BYTE_W-1:0] o_rd_data
);

    logic [orlb_pkg::BYTE_W-1:0] r_mem [orlb_pkg::DEPTH];
    logic [orlb_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.addr] <= i_cmd.wdata;
        end
    end

    // read data holds until the next read so a stalled result keeps its byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/orlb_ctrl.sv
// write pointer and fill count of the ring, memory address generation
// depends on orlb_pkg for sizes, request codes and command types

module orlb_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic                        i_req_type,
    input  logic [orlb_pkg::BYTE_W-1:0] i_byte_in,
    input  logic [orlb_pkg::ADDR_W-1:0] i_read_index,
    output orlb_pkg::t_mem_cmd          o_cmd,
    output orlb_pkg::t_item_info        o_info
);

    logic [orlb_pkg::ADDR_W-1:0] r_wr_pos;
    logic [orlb_pkg::ADDR_W-1:0] n_wr_pos;
    logic [orlb_pkg::CNT_W-1:0]  r_count;
    logic [orlb_pkg::CNT_W-1:0]  n_count;
    logic [orlb_pkg::ADDR_W-1:0] oldest;
    logic                        idx_ok;

    // oldest entry; a full count truncates to zero so oldest equals the write pointer
    assign oldest = r_wr_pos - r_count[orlb_pkg::ADDR_W-1:0];
    assign idx_ok = ({1'b0, i_read_index} < r_count);

    always_comb begin
        n_wr_pos     = r_wr_pos;
        n_count      = r_count;
        o_cmd.wr_en  = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.addr   = r_wr_pos;
        o_cmd.wdata  = i_byte_in;
        o_info.rd_ok = 1'b0;
        if (i_req_type == orlb_pkg::REQ_APPEND) begin
            o_cmd.wr_en = i_take;
            if (r_wr_pos == orlb_pkg::ADDR_W'(orlb_pkg::DEPTH - 1)) begin
                n_wr_pos = '0;
            end else begin
                n_wr_pos = r_wr_pos + 1'b1;
            end
            if (r_count != orlb_pkg::CNT_W'(orlb_pkg::DEPTH)) begin
                n_count = r_count + 1'b1;
            end
        end else begin
            o_info.rd_ok = idx_ok;
            o_cmd.rd_en  = i_take && idx_ok;
            o_cmd.addr   = oldest + i_read_index;
        end
        o_info.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_count  <= '0;
        end else if (i_take) begin
            r_wr_pos <= n_wr_pos;
            r_count  <= n_count;
        end
    end

endmodule

// File: design/overwrite_ring_log_buffer.sv
// top level of the overwrite ring log buffer
// depends on orlb_pkg, orlb_if, orlb_ctrl and orlb_mem

// A ring of 8192 bytes that keeps the most recent log bytes: an append
// transfer stores one byte and, once the ring is full, overwrites the oldest;
// a read transfer returns the byte at a position counted from the oldest
// stored byte, with read_valid clear and read_byte zero when the position is
// not below the stored count. Every request gives exactly one response that
// also carries the stored count after that request. The block takes one
// request per clock while the response side is not stalled; each answer passes
// the registered read port of the byte memory, then the response register.
// Storage is a single-port-write, single-port-read memory with no reset, so
// no clearing pass is needed; a read can only reach bytes already appended.
// A stalled response holds the pipeline; the request side then deasserts
// ready once the stage behind the memory is occupied.

module overwrite_ring_log_buffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    orlb_req_if.sink   i_req,
    orlb_rsp_if.source o_rsp
);

    orlb_pkg::t_mem_cmd          mem_cmd;
    orlb_pkg::t_item_info        item_info;
    logic [orlb_pkg::BYTE_W-1:0] rd_data;
    logic                        take;
    logic                        s1_move;

    // stage 1: memory read in flight
    logic                        r_s1_vld;
    orlb_pkg::t_item_info        r_s1_info;

    // stage 2: response register
    logic                        r_o_vld;
    logic [orlb_pkg::BYTE_W-1:0] r_o_byte;
    logic                        r_o_rvalid;
    logic [orlb_pkg::CNT_W-1:0]  r_o_count;

    // stage 1 advances when the response register is empty or being drained
    assign s1_move     = r_s1_vld && (!r_o_vld || o_rsp.ready);
    assign i_req.ready = !r_s1_vld || s1_move;
    assign take        = i_req.valid && i_req.ready;

    orlb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_req_type   (i_req.req_type),
        .i_byte_in    (i_req.byte_in),
        .i_read_index (i_req.read_index),
        .o_cmd        (mem_cmd),
        .o_info       (item_info)
    );

    orlb_mem u_mem (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (take) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_info <= item_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_move) begin
            r_o_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    // read data register only updates on a valid read, so it is stable here
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_byte   <= r_s1_info.rd_ok ? rd_data : '0;
            r_o_rvalid <= r_s1_info.rd_ok;
            r_o_count  <= r_s1_info.count;
        end
    end

    assign o_rsp.valid        = r_o_vld;
    assign o_rsp.read_byte    = r_o_byte;
    assign o_rsp.read_valid   = r_o_rvalid;
    assign o_rsp.stored_count = r_o_count;

    // count never passes the ring depth
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_count <= orlb_pkg::CNT_W'(orlb_pkg::DEPTH)))
        else $error("stored count above depth");

    // an invalid read or an append reports a zero byte
    a_zero_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !r_o_rvalid) |-> (r_o_byte == '0))
        else $error("nonzero byte without read_valid");

    // an item waiting behind a stalled response is not dropped
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_move) |=> r_s1_vld)
        else $error("stage 1 item lost while stalled");

    // a read is issued to memory only for a read request inside the count
    a_rd_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_cmd.rd_en |-> (take && item_info.rd_ok && !mem_cmd.wr_en))
        else $error("memory read without a valid read request");

endmodule
